### rtl/core/rgb_to_hsv_defines.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef RGB_TO_HSV_DEFINES_SVH
`define RGB_TO_HSV_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rgb_to_hsv: implication check failed");

// The condition must hold at every clock edge outside reset.
`define RTH_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("rgb_to_hsv: invariant check failed");

// A beat entering must leave after the delay given by lat.
`define RTH_ASSERT_LATENCY(label, clk, rst_n, ante, lat, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##lat (cons)) \
		else $error("rgb_to_hsv: latency check failed");

`else

`define RTH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RTH_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RTH_ASSERT_LATENCY(label, clk, rst_n, ante, lat, cons)

`endif

`endif

### rtl/core/rth_pkg.sv
package rth_pkg;

	// Hue is kept in 1/64 degree.
	localparam logic [14:0] HUE_OFF_RED     = 15'd0;
	localparam logic [14:0] HUE_OFF_GREEN   = 15'd7680;
	localparam logic [14:0] HUE_OFF_BLUE    = 15'd15360;
	localparam logic [14:0] HUE_OFF_RED_NEG = 15'd23040;
	localparam logic [14:0] HUE_FULL        = 15'd23040;
	localparam logic [15:0] SAT_ONE         = 16'd32768;

	// Divider geometry: both dividers share the same number of stages.
	localparam int DIV_STAGES = 4;
	localparam int HUE_QW     = 12;
	localparam int SAT_QW     = 16;
	localparam int HUE_STEP   = HUE_QW / DIV_STAGES;
	localparam int SAT_STEP   = SAT_QW / DIV_STAGES;

	// Cycles from an accepted beat to its result strobe.
	localparam int LATENCY = DIV_STAGES + 2;

	// Fields produced by the front stage for both dividers.
	typedef struct packed {
		logic [HUE_QW+7:0] hue_num;
		logic [SAT_QW+7:0] sat_num;
		logic [7:0]        dlt;
		logic [7:0]        mx;
		logic [14:0]       off;
		logic              neg;
	} prep_t;

	// Side information that rides along with the hue divider.
	typedef struct packed {
		logic [14:0] off;
		logic        neg;
		logic        grey;
	} hue_side_t;

endpackage

### rtl/core/rth_prep.sv
module rth_prep
	import rth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_in,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       vld_s1,
	output prep_t      prep_s1
);

	logic        red_max;
	logic        green_max;
	logic [7:0]  mx;
	logic [7:0]  mn;
	logic [7:0]  dlt;
	logic [7:0]  sub_a;
	logic [7:0]  sub_b;
	logic        neg;
	logic [7:0]  absx;
	logic [14:0] off;
	prep_t       prep_d;

	// Pick the maximum component; red wins every tie, green wins over blue.
	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			mx    = red;
			sub_a = green;
			sub_b = blue;
			off   = HUE_OFF_RED;
		end else if (green_max) begin
			mx    = green;
			sub_a = blue;
			sub_b = red;
			off   = HUE_OFF_GREEN;
		end else begin
			mx    = blue;
			sub_a = red;
			sub_b = green;
			off   = HUE_OFF_BLUE;
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		dlt = mx - mn;
	end

	// Signed hue difference as magnitude and sign; a negative red hue wraps at 360.
	always_comb begin
		neg  = sub_a < sub_b;
		absx = neg ? (sub_b - sub_a) : (sub_a - sub_b);
		prep_d.off = (red_max && neg) ? HUE_OFF_RED_NEG : off;
		prep_d.neg = neg;
		prep_d.dlt = dlt;
		prep_d.mx  = mx;
		// 3840 * absx as (absx << 12) - (absx << 8).
		prep_d.hue_num = {absx, 12'd0} - {4'd0, absx, 8'd0};
		// delta * 32768.
		prep_d.sat_num = {1'b0, dlt, 15'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		prep_s1 <= prep_d;
	end

endmodule

### rtl/core/rth_div.sv
module rth_div
	import rth_pkg::*;
#(
	parameter int QW   = 12,
	parameter int STEP = 3,
	parameter int TW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [QW+7:0] num,
	input  logic [7:0]    den,
	input  logic [TW-1:0] tag_in,
	output logic          vld_out,
	output logic [QW-1:0] quo,
	output logic [7:0]    rem,
	output logic [TW-1:0] tag_out
);

	localparam int NS = QW / STEP;

	// Stage k register set holds the state after stage k has run.
	logic          vld_s [NS];
	logic [7:0]    rem_s [NS];
	logic [QW-1:0] wrk_s [NS];
	logic [7:0]    den_s [NS];
	logic [TW-1:0] tag_s [NS];

	// Several restoring division steps; quotient bits shift in as dividend bits shift out.
	function automatic logic [QW+7:0] div_steps(input logic [7:0] r_in,
			input logic [QW-1:0] w_in, input logic [7:0] dv);
		logic [8:0]    r9;
		logic [7:0]    r;
		logic [QW-1:0] w;
		r = r_in;
		w = w_in;
		for (int i = 0; i < STEP; i++) begin
			r9 = {r, w[QW-1]};
			if (r9 >= {1'b0, dv}) begin
				r9 = r9 - {1'b0, dv};
				w  = {w[QW-2:0], 1'b1};
			end else begin
				w  = {w[QW-2:0], 1'b0};
			end
			r = r9[7:0];
		end
		return {r, w};
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic          src_vld;
		logic [7:0]    src_rem;
		logic [QW-1:0] src_wrk;
		logic [7:0]    src_den;
		logic [TW-1:0] src_tag;
		logic [QW+7:0] nxt;

		// The first stage takes the operands; later stages take the stage before.
		if (k == 0) begin : g_first
			assign src_vld = vld_in;
			assign src_rem = num[QW+7:QW];
			assign src_wrk = num[QW-1:0];
			assign src_den = den;
			assign src_tag = tag_in;
		end else begin : g_next
			assign src_vld = vld_s[k-1];
			assign src_rem = rem_s[k-1];
			assign src_wrk = wrk_s[k-1];
			assign src_den = den_s[k-1];
			assign src_tag = tag_s[k-1];
		end

		assign nxt = div_steps(src_rem, src_wrk, src_den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= nxt[QW+7:QW];
			wrk_s[k] <= nxt[QW-1:0];
			den_s[k] <= src_den;
			tag_s[k] <= src_tag;
		end
	end

	assign vld_out = vld_s[NS-1];
	assign quo     = wrk_s[NS-1];
	assign rem     = rem_s[NS-1];
	assign tag_out = tag_s[NS-1];

endmodule

### rtl/core/rgb_to_hsv.sv
// Channel   Direction  Handshake                 Fields
// pixel     in         start high, busy low      red, green, blue
// result    out        done, one cycle           hue, saturation, value
//
// A pixel beat can be taken every cycle; busy never rises.
// Each result strobes done after its beat has passed one front stage, four
// stages in each of the hue and saturation dividers, and one output stage.
// The divider stages set the depth: 3 hue or 4 saturation quotient bits each.
// Reset clears only the valid bits; there is no stall anywhere in the pipe.
`include "rgb_to_hsv_defines.svh"

module rgb_to_hsv
	import rth_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        done,
	output logic [14:0] hue,
	output logic [15:0] saturation,
	output logic [7:0]  value
);

	logic              vld_s1;
	prep_t             prep_s1;
	hue_side_t         hside_s1;
	logic              hvld_s5;
	logic              svld_s5;
	logic [HUE_QW-1:0] hquo_s5;
	logic [SAT_QW-1:0] squo_s5;
	logic [7:0]        hrem_s5;
	logic [7:0]        srem_s5;
	logic [$bits(hue_side_t)-1:0] htag_s5;
	logic [7:0]        mx_s5;
	hue_side_t         hside_s5;
	logic [14:0]       hue_d;
	logic [15:0]       sat_d;

	// The pipe never stalls, so a beat is taken whenever start is high.
	assign busy = 1'b0;

	rth_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.vld_s1  (vld_s1),
		.prep_s1 (prep_s1)
	);

	always_comb begin
		hside_s1.off  = prep_s1.off;
		hside_s1.neg  = prep_s1.neg;
		hside_s1.grey = (prep_s1.dlt == 8'd0);
	end

	// Hue divider: 3840 * |difference| / delta.
	rth_div #(
		.QW   (HUE_QW),
		.STEP (HUE_STEP),
		.TW   ($bits(hue_side_t))
	) u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (prep_s1.hue_num),
		.den     (prep_s1.dlt),
		.tag_in  (hside_s1),
		.vld_out (hvld_s5),
		.quo     (hquo_s5),
		.rem     (hrem_s5),
		.tag_out (htag_s5)
	);

	// Saturation divider: delta * 32768 / max, with max riding along as value.
	rth_div #(
		.QW   (SAT_QW),
		.STEP (SAT_STEP),
		.TW   (8)
	) u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (prep_s1.sat_num),
		.den     (prep_s1.mx),
		.tag_in  (prep_s1.mx),
		.vld_out (svld_s5),
		.quo     (squo_s5),
		.rem     (srem_s5),
		.tag_out (mx_s5)
	);

	assign hside_s5 = hue_side_t'(htag_s5);

	// Add the sector offset; a negative difference subtracts the ceiling; a grey pixel gets hue zero.
	always_comb begin
		if (hside_s5.grey) begin
			hue_d = 15'd0;
		end else if (hside_s5.neg) begin
			hue_d = hside_s5.off - {3'd0, hquo_s5} - {14'd0, (hrem_s5 != 8'd0)};
		end else begin
			hue_d = hside_s5.off + {3'd0, hquo_s5};
		end
		// A black pixel has zero saturation; the remainder plays no part here.
		sat_d = (mx_s5 == 8'd0) ? 16'd0 : squo_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= hvld_s5;
		end
	end

	always_ff @(posedge clk) begin
		hue        <= hue_d;
		saturation <= sat_d;
		value      <= mx_s5;
	end

	// Both dividers must carry the same beats in lockstep.
	`RTH_ASSERT_ALWAYS(a_div_lockstep, clk, arst_n, hvld_s5 == svld_s5)
	// Every accepted beat comes out after the fixed latency.
	`RTH_ASSERT_LATENCY(a_latency, clk, arst_n, start && !busy, LATENCY, done)
	// Hue stays below a full turn.
	`RTH_ASSERT_IMPLY(a_hue_range, clk, arst_n, done, hue < HUE_FULL)
	// Saturation never exceeds one.
	`RTH_ASSERT_IMPLY(a_sat_range, clk, arst_n, done, saturation <= SAT_ONE)
	// The saturation remainder stays below the divisor for a nonblack pixel.
	`RTH_ASSERT_IMPLY(a_sat_rem, clk, arst_n, svld_s5 && (mx_s5 != 8'd0), srem_s5 < mx_s5)

endmodule

### tb/tb_rgb_to_hsv.sv
module tb_rgb_to_hsv;
	import rth_pkg::*;

	// 60 degrees in 1/64 degree.
	localparam int unsigned HUE_SIXTH = 3840;
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_PRINTS = 40;
	localparam int NUM_DIRECTED = 24;

	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] sat;
		logic [7:0]  val;
	} hsv_t;

	// One directed pixel; the expected result is used only when known is set.
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       known;
		hsv_t       want;
	} pixel_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  red = 8'd0;
	logic [7:0]  green = 8'd0;
	logic [7:0]  blue = 8'd0;
	logic        done;
	logic [14:0] hue;
	logic [15:0] saturation;
	logic [7:0]  value;

	hsv_t pending_hsv[$];
	int   errors = 0;

	// Directed pixels: extremes, primaries, secondaries, ties and each hue branch.
	pixel_row_t directed [0:NUM_DIRECTED-1] = '{
		{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     16'd0,     8'd0},
		{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     16'd0,     8'd255},
		{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     16'd0,     8'd128},
		{8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     16'd0,     8'd1},
		{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     16'd32768, 8'd255},
		{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  16'd32768, 8'd255},
		{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 16'd32768, 8'd255},
		{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  16'd32768, 8'd255},
		{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 16'd32768, 8'd255},
		{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 16'd32768, 8'd255},
		{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     16'd32768, 8'd1},
		{8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     16'd0,     8'd0},
		{8'd255, 8'd254, 8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
		{8'd200, 8'd100, 8'd150, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd100, 8'd200, 8'd50,  1'b0, 15'd0,     16'd0,     8'd0},
		{8'd100, 8'd200, 8'd250, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd0,   8'd128, 8'd255, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd255, 8'd255, 8'd254, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd254, 8'd255, 8'd255, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd255, 8'd1,   8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
		{8'd170, 8'd85,  8'd255, 1'b0, 15'd0,     16'd0,     8'd0},
		{8'd0,   8'd1,   8'd1,   1'b0, 15'd0,     16'd0,     8'd0},
		{8'd85,  8'd170, 8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
		{8'd37,  8'd201, 8'd201, 1'b0, 15'd0,     16'd0,     8'd0}
	};

	rgb_to_hsv u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.value      (value)
	);

	always #6 clk = ~clk;

	// Exact integer HSV of one pixel; red wins every tie, green wins over blue.
	function automatic hsv_t hsv_of(input logic [7:0] r8, input logic [7:0] g8,
			input logic [7:0] b8);
		int unsigned r, g, b, mx, mn, dl, num;
		hsv_t res;
		r = {24'd0, r8};
		g = {24'd0, g8};
		b = {24'd0, b8};
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		num = 0;
		if (dl != 0) begin
			if (mx == r) begin
				if (g >= b)
					num = HUE_SIXTH * (g - b);
				else
					num = int'(HUE_FULL) * dl - HUE_SIXTH * (b - g);
			end else if (mx == g) begin
				num = int'(HUE_OFF_GREEN) * dl + HUE_SIXTH * b - HUE_SIXTH * r;
			end else begin
				num = int'(HUE_OFF_BLUE) * dl + HUE_SIXTH * r - HUE_SIXTH * g;
			end
			num = num / dl;
		end
		res.hue = num[14:0];
		res.sat = (mx != 0) ? 16'((dl * int'(SAT_ONE)) / mx) : 16'd0;
		res.val = mx[7:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Sends one pixel beat after a random gap and records what it must produce.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic known, input hsv_t want, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			red <= 8'($urandom);
			green <= 8'($urandom);
			blue <= 8'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy !== 1'b0);
		pending_hsv.push_back(known ? want : hsv_of(r, g, b));
	endtask

	// Holds the sender off until every expected result has come out.
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hsv.size() != 0) @(posedge clk);
	endtask

	// Random pixel, weighted toward greys, ties, tiny values and extremes.
	task automatic rand_pixel(output logic [7:0] r, output logic [7:0] g,
			output logic [7:0] b);
		int hi, lo, base;
		hi = $urandom_range(1, 255);
		lo = $urandom_range(0, hi - 1);
		base = $urandom_range(2, 253);
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(9))
			4: begin
				g = r;
				b = r;
			end
			5: begin
				case ($urandom_range(2))
					0: begin r = 8'(hi); g = 8'(hi); b = 8'(lo); end
					1: begin r = 8'(hi); g = 8'(lo); b = 8'(hi); end
					default: begin r = 8'(lo); g = 8'(hi); b = 8'(hi); end
				endcase
			end
			6: begin
				r = 8'($urandom_range(3));
				g = 8'($urandom_range(3));
				b = 8'($urandom_range(3));
			end
			7: begin
				r = $urandom_range(1) ? 8'd255 : 8'd0;
				g = $urandom_range(1) ? 8'd255 : 8'd0;
				b = $urandom_range(2) == 0 ? 8'($urandom) : ($urandom_range(1) ? 8'd255 : 8'd0);
			end
			8, 9: begin
				r = 8'(base + $urandom_range(2) - 1);
				g = 8'(base + $urandom_range(2) - 1);
				b = 8'(base + $urandom_range(2) - 1);
			end
			default: ;
		endcase
	endtask

	// Every done beat is compared with the oldest expectation.
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_hsv.size() == 0) begin
				report_mismatch($sformatf("result with none expected: hue %0d sat %0d val %0d",
					hue, saturation, value));
			end else begin
				want = pending_hsv.pop_front();
				if (hue !== want.hue)
					report_mismatch($sformatf("hue %0d, expected %0d", hue, want.hue));
				if (saturation !== want.sat)
					report_mismatch($sformatf("saturation %0d, expected %0d",
						saturation, want.sat));
				if (value !== want.val)
					report_mismatch($sformatf("value %0d, expected %0d", value, want.val));
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb_rgb_to_hsv failed");
		$finish;
	end

	initial begin
		int idle_by_phase [4] = '{0, 74, 24, 0};
		int beats_by_phase [4] = '{400, 400, 400, 350};
		logic [7:0] r, g, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, sent back to back.
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].known,
				directed[i].want, 0);
		drain_pipe();

		// Random phases with varying sender gaps; the first and last send back to back.
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < beats_by_phase[ph]; n++) begin
				rand_pixel(r, g, b);
				send_pixel(r, g, b, 1'b0, '0, idle_by_phase[ph]);
				if (ph == 1 && n == 200)
					drain_pipe();
			end
			drain_pipe();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && pending_hsv.size() == 0)
			$display("tb_rgb_to_hsv passed");
		else
			$display("tb_rgb_to_hsv failed");
		$finish;
	end

endmodule
